// File: src/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the component finder
// Command and result codes, the datapath operation set and the status group
// that the controller reads back from the datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int FIELD_W = 7;
    localparam int COMP_W  = 6;
    localparam int KIND_W  = 2;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEMBER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACK,
        OP_EDGE_RD,
        OP_EDGE_WR,
        OP_FIND_INIT,
        OP_NEXT_ROOT,
        OP_START_FWD,
        OP_PASS2,
        OP_ADJ_RD,
        OP_CHK,
        OP_WALK_END,
        OP_POP,
        OP_POPLD,
        OP_FIN_RD,
        OP_START_BACK,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad;
        logic             root_done;
        logic             root_seen;
        logic             nb_end;
        logic             wsp_empty;
        logic             fsp_empty;
        logic             back_pass;
        logic             fin_seen;
    } t_dp_status;

endpackage

// File: src/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl: sequencer of the component finder
// Decodes commands and steps the datapath through both depth-first passes.
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  scc_pkg::t_dp_status i_status,
    output scc_pkg::t_dp_op     o_op
);
    import scc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DECODE    = 13'b0000000000010,
        S_EDGE_RD   = 13'b0000000000100,
        S_EDGE_WR   = 13'b0000000001000,
        S_ACK       = 13'b0000000010000,
        S_FIND_INIT = 13'b0000000100000,
        S_ROOT      = 13'b0000001000000,
        S_RD        = 13'b0000010000000,
        S_CHK       = 13'b0000100000000,
        S_POPLD     = 13'b0001000000000,
        S_P2_POP    = 13'b0010000000000,
        S_P2_SEL    = 13'b0100000000000,
        S_FINISH    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op    = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.cmd) inside
                    CMD_CLEAR:          n_state = S_ACK;
                    CMD_ADD, CMD_REMOVE: n_state = i_status.bad ? S_ACK : S_EDGE_RD;
                    default:            n_state = S_FIND_INIT;
                endcase
            end
            S_EDGE_RD: begin
                o_op    = OP_EDGE_RD;
                n_state = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                o_op    = OP_EDGE_WR;
                n_state = S_ACK;
            end
            S_ACK: begin
                o_op    = OP_ACK;
                n_state = S_IDLE;
            end
            S_FIND_INIT: begin
                o_op    = OP_FIND_INIT;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (i_status.root_done) begin
                    o_op    = OP_PASS2;
                    n_state = S_P2_POP;
                end else if (i_status.root_seen) begin
                    o_op = OP_NEXT_ROOT;
                end else begin
                    o_op    = OP_START_FWD;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (!i_status.nb_end) begin
                    o_op    = OP_ADJ_RD;
                    n_state = S_CHK;
                end else if (i_status.wsp_empty) begin
                    o_op    = OP_WALK_END;
                    n_state = i_status.back_pass ? S_P2_POP : S_ROOT;
                end else begin
                    o_op    = OP_POP;
                    n_state = S_POPLD;
                end
            end
            S_CHK: begin
                o_op    = OP_CHK;
                n_state = S_RD;
            end
            S_POPLD: begin
                o_op    = OP_POPLD;
                n_state = S_RD;
            end
            S_P2_POP: begin
                if (i_status.fsp_empty) begin
                    n_state = S_FINISH;
                end else begin
                    o_op    = OP_FIN_RD;
                    n_state = S_P2_SEL;
                end
            end
            S_P2_SEL: begin
                if (i_status.fin_seen) begin
                    n_state = S_P2_POP;
                end else begin
                    o_op    = OP_START_BACK;
                    n_state = S_RD;
                end
            end
            S_FINISH: begin
                o_op    = OP_FINISH;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: src/scc_dp.sv
// ----------------------------------------------------------------------------
// scc_dp: datapath of the component finder
// Adjacency memory with row valid bits, walk and finish stacks, visited
// marks, the pending member register and the result register.
// ----------------------------------------------------------------------------
module scc_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  scc_pkg::t_dp_op             i_op,
    output scc_pkg::t_dp_status         o_status,
    input  logic [scc_pkg::CMD_W-1:0]   i_command,
    input  logic [scc_pkg::FIELD_W-1:0] i_edge_source,
    input  logic [scc_pkg::FIELD_W-1:0] i_edge_target,
    input  logic [scc_pkg::FIELD_W-1:0] i_new_node_count,
    output logic                        o_strobe,
    output logic [scc_pkg::KIND_W-1:0]  o_item_kind,
    output logic                        o_status_bit,
    output logic [scc_pkg::FIELD_W-1:0] o_member_node,
    output logic [scc_pkg::COMP_W-1:0]  o_component_number,
    output logic                        o_component_end,
    output logic                        o_run_last,
    output logic                        o_majority_found,
    output logic                        o_majority_lost
);
    import scc_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = IDX_W + 1;
    localparam int WE_W  = IDX_W + CNT_W;

    logic [MAX_NODES-1:0] r_adj [MAX_NODES];
    logic [MAX_NODES-1:0] r_adj_valid;
    logic [MAX_NODES-1:0] r_adj_q;
    logic                 r_adj_vq;
    logic [WE_W-1:0]      r_walk [MAX_NODES];
    logic [WE_W-1:0]      r_walk_q;
    logic [IDX_W-1:0]     r_fin [MAX_NODES];
    logic [IDX_W-1:0]     r_fin_q;

    logic [CMD_W-1:0]   r_cmd;
    logic [FIELD_W-1:0] r_src, r_tgt, r_cnt, r_node_count;
    logic               r_held, r_found, r_back;
    logic [MAX_NODES-1:0] r_visited;
    logic [CNT_W-1:0]   r_root, r_cur_nb, r_wsp, r_fsp, r_size;
    logic [IDX_W-1:0]   r_cur_node;
    logic [COMP_W-1:0]  r_comp;
    logic               r_pv, r_p_end;
    logic [FIELD_W-1:0] r_p_node;
    logic [COMP_W-1:0]  r_p_comp;

    logic [FIELD_W-1:0] src_m1, tgt_m1, emit_node;
    logic [IDX_W-1:0]   src_idx, tgt_idx, nb_idx;
    logic [MAX_NODES-1:0] adj_row, bit_mask;
    logic               bad, hit, emit, adj_re;
    logic [IDX_W-1:0]   adj_ra;
    logic [CNT_W-1:0]   wsp_m1, fsp_m1;

    assign src_m1   = r_src - 7'd1;
    assign tgt_m1   = r_tgt - 7'd1;
    assign src_idx  = src_m1[IDX_W-1:0];
    assign tgt_idx  = tgt_m1[IDX_W-1:0];
    assign nb_idx   = r_cur_nb[IDX_W-1:0];
    assign wsp_m1   = r_wsp - 1'b1;
    assign fsp_m1   = r_fsp - 1'b1;
    assign adj_row  = r_adj_vq ? r_adj_q : '0;
    assign bit_mask = {{(MAX_NODES-1){1'b0}}, 1'b1} << tgt_idx;

    always_comb begin
        if (r_cmd == CMD_CLEAR) begin
            bad = r_cnt > 7'(MAX_NODES);
        end else begin
            bad = (r_src == '0) || (r_src > r_node_count) ||
                  (r_tgt == '0) || (r_tgt > r_node_count);
        end
    end

    // The second pass walks the transpose, so the row and column swap roles.
    assign hit = (r_back ? adj_row[r_cur_node] : adj_row[nb_idx]) && !r_visited[nb_idx];
    assign emit = (i_op == OP_START_BACK) || ((i_op == OP_CHK) && hit && r_back);
    assign emit_node = (i_op == OP_START_BACK) ? 7'(r_fin_q) + 7'd1
                                               : 7'(r_cur_nb) + 7'd1;
    assign adj_re = (i_op == OP_EDGE_RD) || (i_op == OP_ADJ_RD);
    assign adj_ra = (i_op == OP_EDGE_RD) ? src_idx : (r_back ? nb_idx : r_cur_node);

    assign o_status.cmd       = r_cmd;
    assign o_status.bad       = bad;
    assign o_status.root_done = 7'(r_root) >= r_node_count;
    assign o_status.root_seen = r_visited[r_root[IDX_W-1:0]];
    assign o_status.nb_end    = 7'(r_cur_nb) >= r_node_count;
    assign o_status.wsp_empty = (r_wsp == '0);
    assign o_status.fsp_empty = (r_fsp == '0);
    assign o_status.back_pass = r_back;
    assign o_status.fin_seen  = r_visited[r_fin_q];

    // Memories.
    always_ff @(posedge i_clk) begin
        if (adj_re) begin
            r_adj_q <= r_adj[adj_ra];
        end
        if (i_op == OP_EDGE_WR) begin
            r_adj[src_idx] <= (r_cmd == CMD_ADD) ? (adj_row | bit_mask)
                                                 : (adj_row & ~bit_mask);
        end
        if ((i_op == OP_CHK) && hit) begin
            r_walk[r_wsp[IDX_W-1:0]] <= {r_cur_node, r_cur_nb + 1'b1};
        end
        if (i_op == OP_POP) begin
            r_walk_q <= r_walk[wsp_m1[IDX_W-1:0]];
        end
        if (!r_back && ((i_op == OP_WALK_END) || (i_op == OP_POP))) begin
            r_fin[r_fsp[IDX_W-1:0]] <= r_cur_node;
        end
        if (i_op == OP_FIN_RD) begin
            r_fin_q <= r_fin[fsp_m1[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adj_valid  <= '0;
            r_adj_vq     <= 1'b0;
            r_node_count <= '0;
            r_held       <= 1'b0;
            r_visited    <= '0;
            r_pv         <= 1'b0;
            r_wsp        <= '0;
            r_fsp        <= '0;
            r_back       <= 1'b0;
            r_found      <= 1'b0;
            r_cmd        <= CMD_CLEAR;
            o_strobe     <= 1'b0;
        end else begin
            o_strobe <= (emit && r_pv) || (i_op == OP_ACK) || (i_op == OP_FINISH);
            if (adj_re) begin
                r_adj_vq <= r_adj_valid[adj_ra];
            end
            if (emit) begin
                if (r_pv) begin
                    o_item_kind        <= KIND_MEMBER;
                    o_status_bit       <= 1'b0;
                    o_member_node      <= r_p_node;
                    o_component_number <= r_p_comp;
                    o_component_end    <= r_p_end;
                    o_run_last         <= 1'b0;
                    o_majority_found   <= 1'b0;
                    o_majority_lost    <= 1'b0;
                end
                r_pv     <= 1'b1;
                r_p_node <= emit_node;
                r_p_comp <= r_comp;
                r_p_end  <= 1'b0;
            end
            case (i_op)
                OP_LOAD: begin
                    r_cmd <= i_command;
                    r_src <= i_edge_source;
                    r_tgt <= i_edge_target;
                    r_cnt <= i_new_node_count;
                end
                OP_ACK: begin
                    o_item_kind        <= KIND_ACK;
                    o_status_bit       <= bad;
                    o_member_node      <= '0;
                    o_component_number <= '0;
                    o_component_end    <= 1'b0;
                    o_run_last         <= 1'b1;
                    o_majority_found   <= 1'b0;
                    o_majority_lost    <= 1'b0;
                    if ((r_cmd == CMD_CLEAR) && !bad) begin
                        r_adj_valid  <= '0;
                        r_node_count <= r_cnt;
                    end
                end
                OP_EDGE_WR: r_adj_valid[src_idx] <= 1'b1;
                OP_FIND_INIT: begin
                    r_visited <= '0;
                    r_root    <= '0;
                    r_wsp     <= '0;
                    r_fsp     <= '0;
                    r_back    <= 1'b0;
                    r_comp    <= '0;
                    r_found   <= 1'b0;
                    r_pv      <= 1'b0;
                end
                OP_NEXT_ROOT: r_root <= r_root + 1'b1;
                OP_START_FWD: begin
                    r_visited[r_root[IDX_W-1:0]] <= 1'b1;
                    r_cur_node <= r_root[IDX_W-1:0];
                    r_cur_nb   <= '0;
                    r_root     <= r_root + 1'b1;
                end
                OP_PASS2: begin
                    r_visited <= '0;
                    r_back    <= 1'b1;
                end
                OP_CHK: begin
                    if (hit) begin
                        r_visited[nb_idx] <= 1'b1;
                        r_wsp      <= r_wsp + 1'b1;
                        r_cur_node <= nb_idx;
                        r_cur_nb   <= '0;
                        r_size     <= r_size + 1'b1;
                    end else begin
                        r_cur_nb <= r_cur_nb + 1'b1;
                    end
                end
                OP_WALK_END: begin
                    if (r_back) begin
                        r_p_end <= 1'b1;
                        r_comp  <= r_comp + 1'b1;
                        if (7'(r_size) > (r_node_count >> 1)) begin
                            r_found <= 1'b1;
                        end
                    end else begin
                        r_fsp <= r_fsp + 1'b1;
                    end
                end
                OP_POP: begin
                    r_wsp <= wsp_m1;
                    if (!r_back) begin
                        r_fsp <= r_fsp + 1'b1;
                    end
                end
                OP_POPLD: begin
                    r_cur_node <= r_walk_q[WE_W-1:CNT_W];
                    r_cur_nb   <= r_walk_q[CNT_W-1:0];
                end
                OP_FIN_RD: r_fsp <= fsp_m1;
                OP_START_BACK: begin
                    r_visited[r_fin_q] <= 1'b1;
                    r_cur_node <= r_fin_q;
                    r_cur_nb   <= '0;
                    r_size     <= {{(CNT_W-1){1'b0}}, 1'b1};
                end
                OP_FINISH: begin
                    o_status_bit     <= 1'b0;
                    o_run_last       <= 1'b1;
                    o_majority_found <= r_found;
                    o_majority_lost  <= !r_found && r_held;
                    r_held           <= r_found;
                    r_pv             <= 1'b0;
                    if (r_pv) begin
                        o_item_kind        <= KIND_MEMBER;
                        o_member_node      <= r_p_node;
                        o_component_number <= r_p_comp;
                        o_component_end    <= r_p_end;
                    end else begin
                        o_item_kind        <= KIND_EMPTY;
                        o_member_node      <= '0;
                        o_component_number <= '0;
                        o_component_end    <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_wsp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_wsp) <= 7'(MAX_NODES)) else $error("walk stack overrun");
    a_fsp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_fsp) <= 7'(MAX_NODES)) else $error("finish stack overrun");
    a_member_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_item_kind == KIND_MEMBER)) |->
            ((o_member_node != '0) && (o_member_node <= r_node_count)))
        else $error("member node out of range");
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_item_kind == KIND_ACK)) |-> (o_run_last && !o_majority_found))
        else $error("acknowledgement not marked last");

endmodule

// File: src/scc_finder_with_majority.sv
// ----------------------------------------------------------------------------
// scc_finder_with_majority: strongly connected components with majority flag
// Holds a directed graph as a bit matrix and lists its components.
// ----------------------------------------------------------------------------
// Usage: drive the command fields and raise start; a command is taken at the
// clock edge where start is high and busy is low. Every result item shows on
// the o_ ports for one cycle with o_strobe high, and the receiver must take
// it then: there is no stall. A clear or a refused edge command goes from
// decode straight to its acknowledgement; an accepted add or remove first
// reads and rewrites the source row. Find runs two depth-first passes; each
// neighbour test is a read of the single adjacency memory port and then a
// check of the bit. Member items stream out during the second pass; the last
// one, or an empty-graph summary, carries run_last and the majority flags.
// busy falls in the cycle in which the last item of a command is shown, so
// the next command can be taken at the edge that ends that cycle. Reset
// empties the graph, sets the node count to zero and forgets any held
// majority; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scc_finder_with_majority #(
    parameter int MAX_NODES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [scc_pkg::CMD_W-1:0]   i_command,
    input  logic [scc_pkg::FIELD_W-1:0] i_edge_source,
    input  logic [scc_pkg::FIELD_W-1:0] i_edge_target,
    input  logic [scc_pkg::FIELD_W-1:0] i_new_node_count,
    output logic                        o_strobe,
    output logic [scc_pkg::KIND_W-1:0]  o_item_kind,
    output logic                        o_status,
    output logic [scc_pkg::FIELD_W-1:0] o_member_node,
    output logic [scc_pkg::COMP_W-1:0]  o_component_number,
    output logic                        o_component_end,
    output logic                        o_run_last,
    output logic                        o_majority_found,
    output logic                        o_majority_lost
);
    import scc_pkg::*;

    t_dp_op     op;
    t_dp_status dp_status;

    scc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (dp_status),
        .o_op     (op)
    );

    scc_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .o_status           (dp_status),
        .i_command          (i_command),
        .i_edge_source      (i_edge_source),
        .i_edge_target      (i_edge_target),
        .i_new_node_count   (i_new_node_count),
        .o_strobe           (o_strobe),
        .o_item_kind        (o_item_kind),
        .o_status_bit       (o_status),
        .o_member_node      (o_member_node),
        .o_component_number (o_component_number),
        .o_component_end    (o_component_end),
        .o_run_last         (o_run_last),
        .o_majority_found   (o_majority_found),
        .o_majority_lost    (o_majority_lost)
    );

endmodule
